// File: src/cpu_operand_fetch_unit_top_defines.svh
// Assertion macros for the operand-fetch unit.
// The default form checks on the rising edge of clk_i and is switched off while rst_ni is low.
// The ALWAYS form also checks while the block is in reset.
`ifndef CPU_OPERAND_FETCH_UNIT_TOP_DEFINES_SVH
`define CPU_OPERAND_FETCH_UNIT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define COFU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("operand fetch unit assertion failed");
`define COFU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("operand fetch unit assertion failed");
`else
`define COFU_ASSERT(lbl, prop)
`define COFU_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: src/cofu_pkg.sv
`timescale 1ns / 1ps

package cofu_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DATA  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_REQ  = 2'd0,
    KIND_DONE = 2'd1,
    KIND_REG  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_ONE   = 4'b0010,
    PH_TWO   = 4'b0100,
    PH_THREE = 4'b1000
  } phase_e;

  // Addressing modes.
  localparam logic [4:0] MODE_IMPLIED    = 5'd0;
  localparam logic [4:0] MODE_U8         = 5'd1;
  localparam logic [4:0] MODE_U16        = 5'd2;
  localparam logic [4:0] MODE_REG        = 5'd3;
  localparam logic [4:0] MODE_IND_DST    = 5'd4;
  localparam logic [4:0] MODE_IND_SRC    = 5'd5;
  localparam logic [4:0] MODE_IND_RMW    = 5'd6;
  localparam logic [4:0] MODE_IND_DST_U8 = 5'd7;
  localparam logic [4:0] MODE_INC_DST    = 5'd8;
  localparam logic [4:0] MODE_DEC_DST    = 5'd9;
  localparam logic [4:0] MODE_INC_SRC    = 5'd10;
  localparam logic [4:0] MODE_DEC_SRC    = 5'd11;
  localparam logic [4:0] MODE_HIGH_U8_RD = 5'd12;
  localparam logic [4:0] MODE_ABS_RD     = 5'd13;
  localparam logic [4:0] MODE_HIGH_U8_WR = 5'd14;
  localparam logic [4:0] MODE_ABS_WR     = 5'd15;
  localparam logic [4:0] MODE_SP_OFS     = 5'd16;
  localparam logic [4:0] MODE_HIGH_DST   = 5'd17;
  localparam logic [4:0] MODE_HIGH_SRC   = 5'd18;

  // Register codes. Codes 12, 14 and 15 all select SP.
  localparam logic [3:0] REG_A  = 4'd0;
  localparam logic [3:0] REG_F  = 4'd1;
  localparam logic [3:0] REG_B  = 4'd2;
  localparam logic [3:0] REG_C  = 4'd3;
  localparam logic [3:0] REG_D  = 4'd4;
  localparam logic [3:0] REG_E  = 4'd5;
  localparam logic [3:0] REG_H  = 4'd6;
  localparam logic [3:0] REG_L  = 4'd7;
  localparam logic [3:0] REG_AF = 4'd8;
  localparam logic [3:0] REG_BC = 4'd9;
  localparam logic [3:0] REG_DE = 4'd10;
  localparam logic [3:0] REG_HL = 4'd11;
  localparam logic [3:0] REG_SP = 4'd12;
  localparam logic [3:0] REG_PC = 4'd13;

  localparam logic [7:0]  F_MASK    = 8'hF0;
  localparam logic [15:0] PAGE_BASE = 16'hFF00;
  localparam int unsigned FLAG_H_BIT = 5;
  localparam int unsigned FLAG_C_BIT = 4;

  typedef struct packed {
    op_e         opcode;
    logic [4:0]  mode;
    logic [3:0]  src_reg;
    logic [3:0]  dst_reg;
    logic [15:0] write_value;
    logic [7:0]  read_data;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] bus_address;
    logic [15:0] fetched_value;
    logic [15:0] dest_address;
    logic        dest_in_memory;
    logic [1:0]  extra_cycles;
    logic [15:0] register_value;
  } out_item_t;

  // Register file write port.
  typedef struct packed {
    logic        en;
    logic [3:0]  idx;
    logic [15:0] value;
  } rf_wr_t;

  // Register file read port indexes and the values they return.
  typedef struct packed {
    logic [3:0] a;
    logic [3:0] b;
  } rf_idx_t;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] sp;
    logic [15:0] pc;
  } rf_rd_t;

  function automatic logic [1:0] mode_extra_cycles(logic [4:0] mode);
    logic [1:0] cyc;
    unique case (mode)
      MODE_U8, MODE_IND_SRC, MODE_IND_RMW, MODE_IND_DST_U8,
      MODE_INC_SRC, MODE_DEC_SRC, MODE_HIGH_U8_WR, MODE_HIGH_SRC: cyc = 2'd1;
      MODE_U16, MODE_HIGH_U8_RD, MODE_ABS_WR, MODE_SP_OFS:         cyc = 2'd2;
      MODE_ABS_RD:                                                 cyc = 2'd3;
      default:                                                     cyc = 2'd0;
    endcase
    return cyc;
  endfunction

  function automatic logic mode_dest_in_memory(logic [4:0] mode);
    logic mem;
    unique case (mode)
      MODE_IND_DST, MODE_IND_RMW, MODE_IND_DST_U8, MODE_INC_DST, MODE_DEC_DST,
      MODE_HIGH_U8_WR, MODE_ABS_WR, MODE_HIGH_DST: mem = 1'b1;
      default:                                      mem = 1'b0;
    endcase
    return mem;
  endfunction

  // Value a register reads back right after it is written with v.
  function automatic logic [15:0] reg_after_write(logic [3:0] idx, logic [15:0] v);
    logic [15:0] r;
    unique case (idx)
      REG_F:                               r = {8'h00, v[7:0] & F_MASK};
      REG_A, REG_B, REG_C, REG_D, REG_E,
      REG_H, REG_L:                        r = {8'h00, v[7:0]};
      REG_AF:                              r = {v[15:8], v[7:0] & F_MASK};
      default:                             r = v;
    endcase
    return r;
  endfunction

endpackage

// File: src/cofu_if.sv
`timescale 1ns / 1ps

// Input channel: one item per transfer.
interface cofu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [4:0]  mode;
  logic [3:0]  src_reg;
  logic [3:0]  dst_reg;
  logic [15:0] write_value;
  logic [7:0]  read_data;

  modport source (
    output valid, opcode, mode, src_reg, dst_reg, write_value, read_data,
    input  ready
  );
  modport sink (
    input  valid, opcode, mode, src_reg, dst_reg, write_value, read_data,
    output ready
  );
endinterface

// Result channel: one result item per transfer.
interface cofu_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] bus_address;
  logic [15:0] fetched_value;
  logic [15:0] dest_address;
  logic        dest_in_memory;
  logic [1:0]  extra_cycles;
  logic [15:0] register_value;

  modport source (
    output valid, kind, bus_address, fetched_value, dest_address, dest_in_memory,
           extra_cycles, register_value,
    input  ready
  );
  modport sink (
    input  valid, kind, bus_address, fetched_value, dest_address, dest_in_memory,
           extra_cycles, register_value,
    output ready
  );
endinterface

// File: src/cpu_operand_fetch_unit_top.sv
`timescale 1ns / 1ps
// Channel  | Direction | Transfer carries
// in_i     | sink      | opcode, mode, src_reg, dst_reg, write_value, read_data
// out_o    | source    | kind, bus_address, fetched_value, dest_address, dest_in_memory,
//          |           | extra_cycles, register_value
//
// An accepted item sits in the input register and is processed by the fetch logic and
// the register file in a cycle in which the output register can take its result; the
// result is loaded into the output register at the edge that ends that cycle.
// One item is processed every cycle as long as the output register is free or drained.
// The reset is asynchronous and active low; it clears the valid flags, all CPU registers,
// SP, PC, the fetch phase and both accumulators. A stalled output holds the result and
// stops processing, and the input register then fills and drops in_i.ready.

`include "cpu_operand_fetch_unit_top_defines.svh"

module cpu_operand_fetch_unit_top import cofu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  cofu_in_if.sink    in_i,
  cofu_out_if.source out_o
);

  logic      in_vld_q;
  in_item_t  in_item_q;
  logic      out_vld_q;
  out_item_t out_item_q;
  logic      fire;
  logic      res_vld;
  out_item_t res;
  rf_idx_t   rf_idx;
  rf_wr_t    rf_wr;
  rf_rd_t    rf_rd;

  // The held item is processed when the output register can take its result.
  // Items that make no result still wait for a free slot, which keeps the rule simple.
  assign fire       = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q.opcode      <= op_e'(in_i.opcode);
      in_item_q.mode        <= in_i.mode;
      in_item_q.src_reg     <= in_i.src_reg;
      in_item_q.dst_reg     <= in_i.dst_reg;
      in_item_q.write_value <= in_i.write_value;
      in_item_q.read_data   <= in_i.read_data;
    end
  end

  cofu_regfile u_regfile (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .idx_i  (rf_idx),
    .wr_i   (rf_wr),
    .rd_o   (rf_rd)
  );

  cofu_fetch u_fetch (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (fire),
    .item_i    (in_item_q),
    .rf_rd_i   (rf_rd),
    .rf_idx_o  (rf_idx),
    .rf_wr_o   (rf_wr),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // Output register: loads a new result on a processing cycle that makes one, otherwise
  // empties when the consumer takes the transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire && res_vld) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_vld) begin
      out_item_q <= res;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.kind           = out_item_q.kind;
  assign out_o.bus_address    = out_item_q.bus_address;
  assign out_o.fetched_value  = out_item_q.fetched_value;
  assign out_o.dest_address   = out_item_q.dest_address;
  assign out_o.dest_in_memory = out_item_q.dest_in_memory;
  assign out_o.extra_cycles   = out_item_q.extra_cycles;
  assign out_o.register_value = out_item_q.register_value;

  // A stalled result must block processing, or it would be overwritten.
  `COFU_ASSERT(a_no_fire_on_stall, out_vld_q && !out_o.ready |-> !fire)
  // A new result only appears after a processing cycle.
  `COFU_ASSERT(a_result_from_fire, $rose(out_vld_q) |-> $past(fire))
  // A held item stays held until it is processed.
  `COFU_ASSERT(a_item_held, in_vld_q && !fire |=> in_vld_q)
  // Reset leaves no result pending.
  `COFU_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_vld_q)

endmodule

// File: src/cofu_regfile.sv
`timescale 1ns / 1ps

module cofu_regfile import cofu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  rf_idx_t idx_i,
  input  rf_wr_t  wr_i,
  output rf_rd_t  rd_o
);

  logic [7:0]  byte_q [8];
  logic [15:0] sp_q;
  logic [15:0] pc_q;

  function automatic logic [15:0] reg_get(logic [3:0] idx);
    logic [15:0] v;
    unique case (idx)
      REG_A, REG_F, REG_B, REG_C, REG_D, REG_E, REG_H, REG_L:
                v = {8'h00, byte_q[idx[2:0]]};
      REG_AF:   v = {byte_q[0], byte_q[1]};
      REG_BC:   v = {byte_q[2], byte_q[3]};
      REG_DE:   v = {byte_q[4], byte_q[5]};
      REG_HL:   v = {byte_q[6], byte_q[7]};
      REG_PC:   v = pc_q;
      default:  v = sp_q;
    endcase
    return v;
  endfunction

  assign rd_o.a  = reg_get(idx_i.a);
  assign rd_o.b  = reg_get(idx_i.b);
  assign rd_o.sp = sp_q;
  assign rd_o.pc = pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '{default: 8'h00};
      sp_q   <= 16'h0000;
      pc_q   <= 16'h0000;
    end else if (wr_i.en) begin
      unique case (wr_i.idx)
        REG_A, REG_B, REG_C, REG_D, REG_E, REG_H, REG_L:
                 byte_q[wr_i.idx[2:0]] <= wr_i.value[7:0];
        REG_F:   byte_q[1] <= wr_i.value[7:0] & F_MASK;
        REG_AF: begin
          byte_q[0] <= wr_i.value[15:8];
          byte_q[1] <= wr_i.value[7:0] & F_MASK;
        end
        REG_BC: begin
          byte_q[2] <= wr_i.value[15:8];
          byte_q[3] <= wr_i.value[7:0];
        end
        REG_DE: begin
          byte_q[4] <= wr_i.value[15:8];
          byte_q[5] <= wr_i.value[7:0];
        end
        REG_HL: begin
          byte_q[6] <= wr_i.value[15:8];
          byte_q[7] <= wr_i.value[7:0];
        end
        REG_PC:  pc_q <= wr_i.value;
        default: sp_q <= wr_i.value;
      endcase
    end
  end

endmodule

// File: src/cofu_fetch.sv
`timescale 1ns / 1ps

module cofu_fetch import cofu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  rf_rd_t    rf_rd_i,
  output rf_idx_t   rf_idx_o,
  output rf_wr_t    rf_wr_o,
  output logic      res_vld_o,
  output out_item_t res_o
);

  phase_e      phase_q, phase_d;
  logic [4:0]  mode_q, mode_d;
  logic [3:0]  lat_rd_q, lat_rd_d;
  logic [15:0] opnd_q, opnd_d;
  logic [15:0] addr_q, addr_d;

  logic        req_en, done_en, reg_en;
  logic [15:0] req_addr, reg_val;
  logic        wr_en;
  logic [3:0]  wr_idx;
  logic [15:0] wr_val;
  logic [7:0]  b;
  logic [15:0] ofs, sp_sum, carries;

  assign b = item_i.read_data;

  // Port a always reads the source; port b reads the latched destination on a bus return.
  assign rf_idx_o.a = item_i.src_reg;
  assign rf_idx_o.b = (item_i.opcode == OP_DATA) ? lat_rd_q : item_i.dst_reg;

  assign ofs     = {{8{b[7]}}, b};
  assign sp_sum  = rf_rd_i.sp + ofs;
  assign carries = sp_sum ^ rf_rd_i.sp ^ ofs;

  always_comb begin
    phase_d  = phase_q;
    mode_d   = mode_q;
    lat_rd_d = lat_rd_q;
    opnd_d   = opnd_q;
    addr_d   = addr_q;
    req_en   = 1'b0;
    req_addr = '0;
    done_en  = 1'b0;
    reg_en   = 1'b0;
    reg_val  = '0;
    wr_en    = 1'b0;
    wr_idx   = REG_A;
    wr_val   = '0;

    unique case (item_i.opcode)
      OP_START: begin
        mode_d   = item_i.mode;
        lat_rd_d = item_i.dst_reg;
        unique case (item_i.mode)
          MODE_U8, MODE_U16, MODE_IND_DST_U8, MODE_HIGH_U8_RD, MODE_ABS_RD,
          MODE_SP_OFS, MODE_HIGH_U8_WR, MODE_ABS_WR: begin
            if (item_i.mode == MODE_HIGH_U8_WR || item_i.mode == MODE_ABS_WR) begin
              opnd_d = rf_rd_i.a;
            end
            req_en   = 1'b1;
            req_addr = rf_rd_i.pc;
            wr_en    = 1'b1;
            wr_idx   = REG_PC;
            wr_val   = rf_rd_i.pc + 16'd1;
          end
          MODE_REG: begin
            opnd_d  = rf_rd_i.a;
            done_en = 1'b1;
          end
          MODE_IND_DST: begin
            addr_d  = rf_rd_i.b;
            opnd_d  = rf_rd_i.a;
            done_en = 1'b1;
          end
          MODE_IND_SRC: begin
            req_en   = 1'b1;
            req_addr = rf_rd_i.a;
          end
          MODE_IND_RMW: begin
            addr_d   = rf_rd_i.a;
            req_en   = 1'b1;
            req_addr = rf_rd_i.a;
          end
          MODE_INC_DST, MODE_DEC_DST: begin
            opnd_d  = rf_rd_i.a;
            addr_d  = rf_rd_i.b;
            wr_en   = 1'b1;
            wr_idx  = item_i.dst_reg;
            wr_val  = (item_i.mode == MODE_INC_DST) ? rf_rd_i.b + 16'd1 : rf_rd_i.b - 16'd1;
            done_en = 1'b1;
          end
          MODE_INC_SRC, MODE_DEC_SRC: begin
            wr_en    = 1'b1;
            wr_idx   = item_i.src_reg;
            wr_val   = (item_i.mode == MODE_INC_SRC) ? rf_rd_i.a + 16'd1 : rf_rd_i.a - 16'd1;
            req_en   = 1'b1;
            req_addr = rf_rd_i.a;
          end
          MODE_HIGH_DST: begin
            opnd_d  = rf_rd_i.a;
            addr_d  = PAGE_BASE + rf_rd_i.b;
            done_en = 1'b1;
          end
          MODE_HIGH_SRC: begin
            addr_d   = PAGE_BASE + rf_rd_i.a;
            req_en   = 1'b1;
            req_addr = PAGE_BASE + rf_rd_i.a;
          end
          default: done_en = 1'b1;
        endcase
        phase_d = req_en ? PH_ONE : PH_IDLE;
      end

      OP_DATA: begin
        if (phase_q != PH_IDLE) begin
          unique case (mode_q)
            MODE_U8, MODE_IND_SRC, MODE_IND_RMW, MODE_INC_SRC, MODE_DEC_SRC,
            MODE_HIGH_SRC: begin
              opnd_d  = {8'h00, b};
              done_en = 1'b1;
            end
            MODE_IND_DST_U8: begin
              opnd_d  = {8'h00, b};
              addr_d  = rf_rd_i.b;
              done_en = 1'b1;
            end
            MODE_U16: begin
              if (phase_q == PH_ONE) begin
                opnd_d   = {8'h00, b};
                req_en   = 1'b1;
                req_addr = rf_rd_i.pc;
                wr_en    = 1'b1;
                wr_idx   = REG_PC;
                wr_val   = rf_rd_i.pc + 16'd1;
                phase_d  = PH_TWO;
              end else begin
                opnd_d  = opnd_q | {b, 8'h00};
                done_en = 1'b1;
              end
            end
            MODE_HIGH_U8_RD: begin
              if (phase_q == PH_ONE) begin
                addr_d   = {PAGE_BASE[15:8], b};
                req_en   = 1'b1;
                req_addr = {PAGE_BASE[15:8], b};
                phase_d  = PH_TWO;
              end else begin
                opnd_d  = {8'h00, b};
                done_en = 1'b1;
              end
            end
            MODE_ABS_RD: begin
              if (phase_q == PH_ONE) begin
                addr_d   = {8'h00, b};
                req_en   = 1'b1;
                req_addr = rf_rd_i.pc;
                wr_en    = 1'b1;
                wr_idx   = REG_PC;
                wr_val   = rf_rd_i.pc + 16'd1;
                phase_d  = PH_TWO;
              end else if (phase_q == PH_TWO) begin
                addr_d   = addr_q | {b, 8'h00};
                req_en   = 1'b1;
                req_addr = addr_q | {b, 8'h00};
                phase_d  = PH_THREE;
              end else begin
                opnd_d  = {8'h00, b};
                done_en = 1'b1;
              end
            end
            MODE_HIGH_U8_WR: begin
              addr_d  = {PAGE_BASE[15:8], b};
              done_en = 1'b1;
            end
            MODE_ABS_WR: begin
              if (phase_q == PH_ONE) begin
                addr_d   = {8'h00, b};
                req_en   = 1'b1;
                req_addr = rf_rd_i.pc;
                wr_en    = 1'b1;
                wr_idx   = REG_PC;
                wr_val   = rf_rd_i.pc + 16'd1;
                phase_d  = PH_TWO;
              end else begin
                addr_d  = addr_q | {b, 8'h00};
                done_en = 1'b1;
              end
            end
            MODE_SP_OFS: begin
              opnd_d  = sp_sum;
              wr_en   = 1'b1;
              wr_idx  = REG_F;
              wr_val  = '0;
              wr_val[FLAG_H_BIT] = carries[4];
              wr_val[FLAG_C_BIT] = carries[8];
              done_en = 1'b1;
            end
            default: phase_d = PH_IDLE;
          endcase
          if (done_en) begin
            phase_d = PH_IDLE;
          end
        end
      end

      OP_WRITE: begin
        wr_en   = 1'b1;
        wr_idx  = item_i.dst_reg;
        wr_val  = item_i.write_value;
        reg_en  = 1'b1;
        reg_val = reg_after_write(item_i.dst_reg, item_i.write_value);
      end

      default: begin
        reg_en  = 1'b1;
        reg_val = rf_rd_i.b;
      end
    endcase
  end

  always_comb begin
    res_o = '0;
    if (req_en) begin
      res_o.kind        = KIND_REQ;
      res_o.bus_address = req_addr;
    end else if (done_en) begin
      res_o.kind           = KIND_DONE;
      res_o.fetched_value  = opnd_d;
      res_o.dest_address   = addr_d;
      res_o.dest_in_memory = mode_dest_in_memory(mode_d);
      res_o.extra_cycles   = mode_extra_cycles(mode_d);
    end else begin
      res_o.kind           = KIND_REG;
      res_o.register_value = reg_val;
    end
  end

  assign res_vld_o    = req_en || done_en || reg_en;
  assign rf_wr_o.en    = step_i && wr_en;
  assign rf_wr_o.idx   = wr_idx;
  assign rf_wr_o.value = wr_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      mode_q   <= '0;
      lat_rd_q <= '0;
      opnd_q   <= '0;
      addr_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      mode_q   <= mode_d;
      lat_rd_q <= lat_rd_d;
      opnd_q   <= opnd_d;
      addr_q   <= addr_d;
    end
  end

endmodule

// File: tb/cpu_operand_fetch_unit_top_test.sv
`timescale 1ns / 1ps

module cpu_operand_fetch_unit_top_test;
  import cofu_pkg::*;

  // Codes outside the named set that the block still has to handle.
  localparam logic [4:0] MODE_UNUSED_TOP = 5'd31;
  localparam logic [3:0] REG_SP_ALT0     = 4'd14;
  localparam logic [3:0] REG_SP_ALT1     = 4'd15;

  // How a row of the directed table is checked.
  localparam int BY_MODEL  = -1;
  localparam int NO_RESULT = 0;
  localparam int TYPED     = 1;

  localparam int unsigned ITEMS_TOTAL  = 550;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned HOLD_CYCLES  = 64;
  localparam int unsigned IDLE_PERCENT = 29;

  logic clk = 1'b0;
  logic rst_n;

  cofu_in_if  in_if ();
  cofu_out_if out_if ();

  cpu_operand_fetch_unit_top u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the register file and the fetch
  // sequencer. It is advanced once for every input transfer, in the order the
  // block accepts them, so the store of pending results lines up with the
  // order in which the block must produce them.
  // ---------------------------------------------------------------------------
  logic [7:0]  gpr [8];
  logic [15:0] sp_m, pc_m, operand_m, address_m;
  logic [4:0]  mode_m;
  logic [3:0]  dst_m;
  int unsigned fetch_step;  // 0 means no fetch in progress
  out_item_t   model_res;

  out_item_t   pending_results[$];

  int unsigned errors;
  int unsigned n_in, n_ignored, n_results, n_checked;
  logic [31:0] modes_hit;

  // Shared between the stimulus and the receiver process.
  bit quiet;     // no idling on either side while set
  bit hold_req;  // asks the receiver for one long hold-off

  function automatic out_item_t result_of(kind_e k, logic [15:0] bus, logic [15:0] fetched,
                                          logic [15:0] dest, logic mem, logic [1:0] extra,
                                          logic [15:0] regv);
    out_item_t r;
    r.kind           = k;
    r.bus_address    = bus;
    r.fetched_value  = fetched;
    r.dest_address   = dest;
    r.dest_in_memory = mem;
    r.extra_cycles   = extra;
    r.register_value = regv;
    return r;
  endfunction

  // Destination-in-memory flag and extra machine cycles of each mode.
  function automatic logic [2:0] mode_cost(logic [4:0] mode);
    logic [2:0] c;
    case (mode)
      MODE_U8, MODE_IND_SRC, MODE_INC_SRC, MODE_DEC_SRC, MODE_HIGH_SRC: c = 3'b001;
      MODE_U16, MODE_HIGH_U8_RD, MODE_SP_OFS:                            c = 3'b010;
      MODE_ABS_RD:                                                       c = 3'b011;
      MODE_IND_DST, MODE_INC_DST, MODE_DEC_DST, MODE_HIGH_DST:           c = 3'b100;
      MODE_IND_RMW, MODE_IND_DST_U8, MODE_HIGH_U8_WR:                    c = 3'b101;
      MODE_ABS_WR:                                                       c = 3'b110;
      default:                                                           c = 3'b000;
    endcase
    return c;
  endfunction

  // Byte registers read zero-extended; codes 12, 14 and 15 are all SP.
  function automatic logic [15:0] rf_read(logic [3:0] r);
    logic [15:0] v;
    case (r)
      REG_AF:  v = {gpr[REG_A[2:0]], gpr[REG_F[2:0]]};
      REG_BC:  v = {gpr[REG_B[2:0]], gpr[REG_C[2:0]]};
      REG_DE:  v = {gpr[REG_D[2:0]], gpr[REG_E[2:0]]};
      REG_HL:  v = {gpr[REG_H[2:0]], gpr[REG_L[2:0]]};
      REG_PC:  v = pc_m;
      default: v = (r < REG_AF) ? {8'h00, gpr[r[2:0]]} : sp_m;
    endcase
    return v;
  endfunction

  // F only keeps its upper nibble, whether written alone or as part of AF.
  function automatic void rf_write(logic [3:0] r, logic [15:0] v);
    case (r)
      REG_AF: begin
        gpr[REG_A[2:0]] = v[15:8];
        gpr[REG_F[2:0]] = v[7:0] & F_MASK;
      end
      REG_BC: begin
        gpr[REG_B[2:0]] = v[15:8];
        gpr[REG_C[2:0]] = v[7:0];
      end
      REG_DE: begin
        gpr[REG_D[2:0]] = v[15:8];
        gpr[REG_E[2:0]] = v[7:0];
      end
      REG_HL: begin
        gpr[REG_H[2:0]] = v[15:8];
        gpr[REG_L[2:0]] = v[7:0];
      end
      REG_PC: pc_m = v;
      default: begin
        if (r == REG_F) gpr[REG_F[2:0]] = v[7:0] & F_MASK;
        else if (r < REG_AF) gpr[r[2:0]] = v[7:0];
        else sp_m = v;
      end
    endcase
  endfunction

  function automatic void bus_req(logic [15:0] a, int unsigned next_step);
    fetch_step = next_step;
    model_res  = result_of(KIND_REQ, a, 16'h0, 16'h0, 1'b0, 2'd0, 16'h0);
  endfunction

  function automatic void pc_req(int unsigned next_step);
    logic [15:0] a;
    a    = pc_m;
    pc_m = pc_m + 16'd1;
    bus_req(a, next_step);
  endfunction

  function automatic void fetch_done();
    logic [2:0] c;
    c          = mode_cost(mode_m);
    fetch_step = 0;
    model_res  = result_of(KIND_DONE, 16'h0, operand_m, address_m, c[2], c[1:0], 16'h0);
  endfunction

  // Advances the predictor by one accepted item. Returns 1 when the item
  // causes a result, which is then left in model_res.
  function automatic bit predict_transfer(in_item_t it);
    bit          produced;
    logic [15:0] a, ofs;
    logic [16:0] sum, carries;
    produced  = 1'b1;
    model_res = '0;
    case (it.opcode)
      OP_START: begin
        mode_m     = it.mode;
        dst_m      = it.dst_reg;
        fetch_step = 0;
        case (it.mode)
          MODE_U8, MODE_U16, MODE_IND_DST_U8, MODE_HIGH_U8_RD, MODE_ABS_RD, MODE_SP_OFS:
            pc_req(1);
          MODE_HIGH_U8_WR, MODE_ABS_WR: begin
            operand_m = rf_read(it.src_reg);
            pc_req(1);
          end
          MODE_REG: begin
            operand_m = rf_read(it.src_reg);
            fetch_done();
          end
          MODE_IND_DST: begin
            address_m = rf_read(it.dst_reg);
            operand_m = rf_read(it.src_reg);
            fetch_done();
          end
          MODE_IND_SRC: bus_req(rf_read(it.src_reg), 1);
          MODE_IND_RMW: begin
            address_m = rf_read(it.src_reg);
            bus_req(address_m, 1);
          end
          MODE_INC_DST, MODE_DEC_DST: begin
            operand_m = rf_read(it.src_reg);
            a         = rf_read(it.dst_reg);
            address_m = a;
            rf_write(it.dst_reg, (it.mode == MODE_INC_DST) ? a + 16'd1 : a - 16'd1);
            fetch_done();
          end
          MODE_INC_SRC, MODE_DEC_SRC: begin
            a = rf_read(it.src_reg);
            rf_write(it.src_reg, (it.mode == MODE_INC_SRC) ? a + 16'd1 : a - 16'd1);
            bus_req(a, 1);
          end
          MODE_HIGH_DST: begin
            operand_m = rf_read(it.src_reg);
            address_m = PAGE_BASE + rf_read(it.dst_reg);
            fetch_done();
          end
          MODE_HIGH_SRC: begin
            address_m = PAGE_BASE + rf_read(it.src_reg);
            bus_req(address_m, 1);
          end
          default: fetch_done();
        endcase
      end
      OP_DATA: begin
        if (fetch_step == 0) begin
          produced = 1'b0;
        end else begin
          case (mode_m)
            MODE_U8, MODE_IND_SRC, MODE_IND_RMW, MODE_INC_SRC, MODE_DEC_SRC,
            MODE_HIGH_SRC: begin
              operand_m = {8'h00, it.read_data};
              fetch_done();
            end
            MODE_IND_DST_U8: begin
              operand_m = {8'h00, it.read_data};
              address_m = rf_read(dst_m);
              fetch_done();
            end
            MODE_U16: begin
              if (fetch_step == 1) begin
                operand_m = {8'h00, it.read_data};
                pc_req(2);
              end else begin
                operand_m = operand_m | {it.read_data, 8'h00};
                fetch_done();
              end
            end
            MODE_HIGH_U8_RD: begin
              if (fetch_step == 1) begin
                address_m = PAGE_BASE + {8'h00, it.read_data};
                bus_req(address_m, 2);
              end else begin
                operand_m = {8'h00, it.read_data};
                fetch_done();
              end
            end
            MODE_ABS_RD: begin
              if (fetch_step == 1) begin
                address_m = {8'h00, it.read_data};
                pc_req(2);
              end else if (fetch_step == 2) begin
                address_m = address_m | {it.read_data, 8'h00};
                bus_req(address_m, 3);
              end else begin
                operand_m = {8'h00, it.read_data};
                fetch_done();
              end
            end
            MODE_HIGH_U8_WR: begin
              address_m = PAGE_BASE + {8'h00, it.read_data};
              fetch_done();
            end
            MODE_ABS_WR: begin
              if (fetch_step == 1) begin
                address_m = {8'h00, it.read_data};
                pc_req(2);
              end else begin
                address_m = address_m | {it.read_data, 8'h00};
                fetch_done();
              end
            end
            MODE_SP_OFS: begin
              // H and C come from the carries out of bits 3 and 7 of the low byte.
              ofs        = {{8{it.read_data[7]}}, it.read_data};
              sum        = {1'b0, sp_m} + {1'b0, ofs};
              carries    = sum ^ {1'b0, sp_m ^ ofs};
              operand_m  = sum[15:0];
              gpr[REG_F[2:0]] = {2'b00, carries[4], carries[8], 4'h0};
              fetch_done();
            end
            default: begin
              fetch_step = 0;
              produced   = 1'b0;
            end
          endcase
        end
      end
      default: begin
        // Register write or read: the result carries the value after the access.
        if (it.opcode == OP_WRITE) rf_write(it.dst_reg, it.write_value);
        model_res = result_of(KIND_REG, 16'h0, 16'h0, 16'h0, 1'b0, 2'd0,
                              rf_read(it.dst_reg));
      end
    endcase
    return produced;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver. Each call offers one item, possibly after some idle cycles,
  // and returns at the edge where the transfer happens. The predictor runs at
  // that same edge, so the caller can look at fetch_step to shape what comes
  // next. A row of the directed table may carry its own expected result,
  // which then replaces the predicted one in the store.
  // ---------------------------------------------------------------------------
  task automatic send_item(in_item_t it, int n_typed = BY_MODEL, out_item_t typed = '0);
    bit produced;
    while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.opcode      <= it.opcode;
    in_if.mode        <= it.mode;
    in_if.src_reg     <= it.src_reg;
    in_if.dst_reg     <= it.dst_reg;
    in_if.write_value <= it.write_value;
    in_if.read_data   <= it.read_data;
    do @(posedge clk); while (!in_if.ready);

    produced = predict_transfer(it);
    if (n_typed == BY_MODEL) begin
      if (produced) pending_results.push_back(model_res);
    end else if (n_typed == TYPED) begin
      pending_results.push_back(typed);
    end
    n_in++;
    if (produced) n_results++;
    else n_ignored++;
    if (it.opcode == OP_START) modes_hit[it.mode] = 1'b1;
  endtask

  // Every field random, so that bits the block should ignore toggle as well.
  function automatic in_item_t rand_item(op_e op);
    in_item_t it;
    it.opcode      = op;
    it.mode        = 5'($urandom_range(31));
    it.src_reg     = 4'($urandom_range(15));
    it.dst_reg     = 4'($urandom_range(15));
    it.write_value = 16'($urandom_range(16'hFFFF));
    it.read_data   = 8'($urandom_range(8'hFF));
    return it;
  endfunction

  function automatic in_item_t rand_access();
    return rand_item(($urandom_range(1) == 0) ? OP_WRITE : OP_READ);
  endfunction

  // Directed table.
  in_item_t  dir_in[$];
  int        dir_n[$];
  out_item_t dir_res[$];

  task automatic add_row(op_e op, logic [4:0] mode, logic [3:0] rs, logic [3:0] rd,
                         logic [15:0] wv, logic [7:0] rb, int n = BY_MODEL,
                         out_item_t r = '0);
    in_item_t it;
    it.opcode      = op;
    it.mode        = mode;
    it.src_reg     = rs;
    it.dst_reg     = rd;
    it.write_value = wv;
    it.read_data   = rb;
    dir_in.push_back(it);
    dir_n.push_back(n);
    dir_res.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every result transfer is matched against the oldest
  // pending expectation, field by field.
  // ---------------------------------------------------------------------------
  out_item_t want;

  function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%04h, got 0x%04h",
               $time, name, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: result transfer with nothing expected, kind %0d",
                 $time, out_if.kind);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 16'(want.kind), 16'(out_if.kind));
        check_field("bus_address", want.bus_address, out_if.bus_address);
        check_field("fetched_value", want.fetched_value, out_if.fetched_value);
        check_field("dest_address", want.dest_address, out_if.dest_address);
        check_field("dest_in_memory", 16'(want.dest_in_memory), 16'(out_if.dest_in_memory));
        check_field("extra_cycles", 16'(want.extra_cycles), 16'(out_if.extra_cycles));
        check_field("register_value", want.register_value, out_if.register_value);
        n_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. It stalls at random except in the quiet stretch, and once, on
  // request, holds ready low for a long fixed count so that the output
  // register and then the input register fill up and in_i.ready drops.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    bit          hold_used;
    hold_left    = 0;
    hold_used    = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Watchdog: ends the run if no transfer happens on either side for too long.
  initial begin
    int unsigned still;
    still = 0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) still = 0;
        else still++;
        if (still >= STALL_LIMIT) begin
          $display("%0t ns: no transfer for %0d cycles, %0d results still pending",
                   $time, still, pending_results.size());
          $display("** cpu_operand_fetch_unit_top: FAILED **");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random traffic, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    in_item_t    item;
    int unsigned k, guard, sel;

    in_if.valid       = 1'b0;
    in_if.opcode      = '0;
    in_if.mode        = '0;
    in_if.src_reg     = '0;
    in_if.dst_reg     = '0;
    in_if.write_value = '0;
    in_if.read_data   = '0;
    rst_n             = 1'b0;
    quiet             = 1'b0;
    hold_req          = 1'b0;
    errors            = 0;
    n_in              = 0;
    n_ignored         = 0;
    n_results         = 0;
    n_checked         = 0;
    modes_hit         = '0;

    // Predictor reset state matches the block's: everything cleared.
    gpr        = '{default: 8'h00};
    sp_m       = 16'h0;
    pc_m       = 16'h0;
    operand_m  = 16'h0;
    address_m  = 16'h0;
    mode_m     = MODE_IMPLIED;
    dst_m      = REG_A;
    fetch_step = 0;

    // Register reads right after reset and the write extremes, including the
    // F mask, then flag generation, page wrap, byte-sized pointers, an
    // abandoned fetch, stray data returns and register access during a fetch.
    add_row(OP_READ, MODE_IMPLIED, REG_A, REG_PC, 16'h0, 8'h00, TYPED,
            result_of(KIND_REG, 16'h0, 16'h0, 16'h0, 1'b0, 2'd0, 16'h0000));
    add_row(OP_WRITE, MODE_IMPLIED, REG_A, REG_AF, 16'hFFFF, 8'h00, TYPED,
            result_of(KIND_REG, 16'h0, 16'h0, 16'h0, 1'b0, 2'd0, 16'hFFF0));
    add_row(OP_WRITE, MODE_IMPLIED, REG_A, REG_SP, 16'hFFFF, 8'h00, TYPED,
            result_of(KIND_REG, 16'h0, 16'h0, 16'h0, 1'b0, 2'd0, 16'hFFFF));
    add_row(OP_WRITE, MODE_IMPLIED, REG_A, REG_HL, 16'h00FF, 8'h00, TYPED,
            result_of(KIND_REG, 16'h0, 16'h0, 16'h0, 1'b0, 2'd0, 16'h00FF));
    // Implied mode reports the accumulators untouched, still zero from reset.
    add_row(OP_START, MODE_IMPLIED, REG_A, REG_A, 16'h0, 8'h00, TYPED,
            result_of(KIND_DONE, 16'h0, 16'h0, 16'h0, 1'b0, 2'd0, 16'h0));
    add_row(OP_DATA, MODE_IMPLIED, REG_A, REG_A, 16'h0, 8'hFF, NO_RESULT);
    add_row(OP_START, MODE_SP_OFS, REG_A, REG_A, 16'h0, 8'h00, TYPED,
            result_of(KIND_REQ, 16'h0000, 16'h0, 16'h0, 1'b0, 2'd0, 16'h0));
    add_row(OP_DATA, MODE_IMPLIED, REG_A, REG_A, 16'h0, 8'h01);
    add_row(OP_READ, MODE_IMPLIED, REG_A, REG_F, 16'h0, 8'h00);
    add_row(OP_START, MODE_HIGH_SRC, REG_SP, REG_A, 16'h0, 8'h00);
    add_row(OP_DATA, MODE_IMPLIED, REG_A, REG_A, 16'h0, 8'hFF);
    add_row(OP_START, MODE_INC_SRC, REG_L, REG_A, 16'h0, 8'h00);
    add_row(OP_DATA, MODE_IMPLIED, REG_A, REG_A, 16'h0, 8'h80);
    add_row(OP_START, MODE_DEC_DST, REG_A, REG_B, 16'h0, 8'h00);
    add_row(OP_START, MODE_ABS_RD, REG_A, REG_A, 16'h0, 8'h00);
    add_row(OP_START, MODE_UNUSED_TOP, REG_A, REG_A, 16'h0, 8'h00);
    add_row(OP_DATA, MODE_IMPLIED, REG_A, REG_A, 16'h0, 8'h55, NO_RESULT);
    add_row(OP_WRITE, MODE_IMPLIED, REG_A, REG_PC, 16'hFFFF, 8'h00, TYPED,
            result_of(KIND_REG, 16'h0, 16'h0, 16'h0, 1'b0, 2'd0, 16'hFFFF));
    add_row(OP_START, MODE_U16, REG_A, REG_A, 16'h0, 8'h00, TYPED,
            result_of(KIND_REQ, 16'hFFFF, 16'h0, 16'h0, 1'b0, 2'd0, 16'h0));
    add_row(OP_DATA, MODE_IMPLIED, REG_A, REG_A, 16'h0, 8'h34);
    add_row(OP_DATA, MODE_IMPLIED, REG_A, REG_A, 16'h0, 8'h12);
    add_row(OP_READ, MODE_IMPLIED, REG_A, REG_SP_ALT0, 16'h0, 8'h00);
    add_row(OP_WRITE, MODE_IMPLIED, REG_A, REG_SP_ALT1, 16'h8000, 8'h00, TYPED,
            result_of(KIND_REG, 16'h0, 16'h0, 16'h0, 1'b0, 2'd0, 16'h8000));
    add_row(OP_START, MODE_ABS_WR, REG_SP, REG_A, 16'h0, 8'h00);
    add_row(OP_WRITE, MODE_IMPLIED, REG_A, REG_PC, 16'h0000, 8'h00, TYPED,
            result_of(KIND_REG, 16'h0, 16'h0, 16'h0, 1'b0, 2'd0, 16'h0000));
    add_row(OP_DATA, MODE_IMPLIED, REG_A, REG_A, 16'h0, 8'h00);
    add_row(OP_DATA, MODE_IMPLIED, REG_A, REG_A, 16'h0, 8'hFF);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < dir_in.size(); k++) send_item(dir_in[k], dir_n[k], dir_res[k]);

    // Random traffic. Most of it is complete fetch sequences with random
    // content, so that every step of the multi-byte modes is reached; register
    // accesses are mixed in during fetches, some fetches are abandoned, and
    // the rest is loose register traffic, stray data returns and pure noise.
    while (n_in < ITEMS_TOTAL) begin
      if (n_results >= 150) hold_req = 1'b1;
      quiet = (n_results >= 300) && (n_results < 380);
      sel   = $urandom_range(99);
      if (sel < 70) begin
        item = rand_item(OP_START);
        item.mode = ($urandom_range(99) < 85) ? 5'($urandom_range(18))
                                               : 5'($urandom_range(31, 19));
        send_item(item);
        guard = 0;
        while (fetch_step != 0 && guard < 8) begin
          guard++;
          sel = $urandom_range(99);
          if (sel < 4) break;
          if (sel < 14) send_item(rand_access());
          else send_item(rand_item(OP_DATA));
        end
      end else if (sel < 85) begin
        send_item(rand_access());
      end else if (sel < 95) begin
        send_item(rand_item(OP_DATA));
      end else begin
        send_item(rand_item(op_e'($urandom_range(3))));
      end
    end
    in_if.valid <= 1'b0;

    // Drain, then allow the pipeline a few more edges so that a stray extra
    // result would still be seen by the checker.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d input transfers (%0d without a result) and %0d checked results,",
             n_in, n_ignored, n_checked);
    $display("with %0d of 19 addressing modes started, a long output hold-off and a no-idle stretch.",
             $countones(modes_hit[18:0]));
    if (errors == 0) begin
      $display("** cpu_operand_fetch_unit_top: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** cpu_operand_fetch_unit_top: FAILED **");
    end
    $finish;
  end

endmodule
